FILE: rtl/cdts_pkg.sv
// Shared types, codes and helpers for the clock date/time set editor.
package cdts_pkg;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_SELECT = 3'd1,
    ACT_LEFT   = 3'd2,
    ACT_RIGHT  = 3'd3,
    ACT_UP     = 3'd4,
    ACT_DOWN   = 3'd5,
    ACT_LOAD   = 3'd6
  } action_t;

  // Cursor positions
  localparam logic [2:0] FLD_WEEKDAY = 3'd0;
  localparam logic [2:0] FLD_DATE    = 3'd1;
  localparam logic [2:0] FLD_MONTH   = 3'd2;
  localparam logic [2:0] FLD_YEAR    = 3'd3;
  localparam logic [2:0] FLD_HOUR    = 3'd4;
  localparam logic [2:0] FLD_MINUTE  = 3'd5;
  localparam logic [2:0] FLD_SECOND  = 3'd6;

  localparam logic [2:0] WEEKDAY_MAX = 3'd7;
  localparam logic [4:0] DATE_MAX    = 5'd31;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [5:0] MINSEC_MAX  = 6'd59;

  typedef struct packed {
    action_t    action;
    logic [2:0] load_weekday;
    logic [4:0] load_day_of_month;
    logic [3:0] load_month;
    logic [6:0] load_year;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_item_t;

  typedef struct packed {
    logic       editing;
    logic [2:0] cursor;
    logic [2:0] weekday;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [6:0] year;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       commit;
  } out_item_t;

  typedef struct packed {
    logic       active;
    logic [2:0] cursor;
    logic [2:0] weekday;
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } state_t;

  // Wrapping step over lo..hi on a value of up to 7 bits.
  function automatic logic [6:0] wrap_step(logic [6:0] v, logic [6:0] lo, logic [6:0] hi,
                                           logic up);
    logic [6:0] r;
    if (up) begin
      r = (v >= hi) ? lo : v + 7'd1;
    end else begin
      r = (v <= lo) ? hi : v - 7'd1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/cdts_in_if.sv
// Request channel: one editor event with the clock values to load.
interface cdts_in_if;
  logic               valid;
  logic               ready;
  cdts_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/cdts_out_if.sv
// Result channel: editor state after one request.
interface cdts_out_if;
  logic                valid;
  logic                ready;
  cdts_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/cdts_step.sv
// Next-state logic of the editor for one request.
module cdts_step (
  input  cdts_pkg::state_t   cur,
  input  cdts_pkg::in_item_t req,
  output cdts_pkg::state_t   nxt,
  output logic               commit
);

  logic       up;
  logic [6:0] wd_step;
  logic [6:0] dt_step;
  logic [6:0] mo_step;
  logic [6:0] hr_step;
  logic [6:0] mi_step;
  logic [6:0] se_step;
  logic [6:0] yr_step;
  cdts_pkg::state_t stepped;

  assign up = (req.action == cdts_pkg::ACT_UP);

  assign wd_step = cdts_pkg::wrap_step({4'd0, cur.weekday}, 7'd1,
                                       {4'd0, cdts_pkg::WEEKDAY_MAX}, up);
  assign dt_step = cdts_pkg::wrap_step({2'd0, cur.date}, 7'd1,
                                       {2'd0, cdts_pkg::DATE_MAX}, up);
  assign mo_step = cdts_pkg::wrap_step({3'd0, cur.month}, 7'd1,
                                       {3'd0, cdts_pkg::MONTH_MAX}, up);
  assign hr_step = cdts_pkg::wrap_step({2'd0, cur.hour}, 7'd0,
                                       {2'd0, cdts_pkg::HOUR_MAX}, up);
  assign mi_step = cdts_pkg::wrap_step({1'b0, cur.minute}, 7'd0,
                                       {1'b0, cdts_pkg::MINSEC_MAX}, up);
  assign se_step = cdts_pkg::wrap_step({1'b0, cur.second}, 7'd0,
                                       {1'b0, cdts_pkg::MINSEC_MAX}, up);

  // year saturates instead of wrapping
  always_comb begin
    yr_step = cur.year;
    if (up) begin
      if (cur.year < cdts_pkg::YEAR_MAX) yr_step = cur.year + 7'd1;
    end else begin
      if (cur.year != 7'd0) yr_step = cur.year - 7'd1;
    end
  end

  always_comb begin
    stepped = cur;
    unique case (cur.cursor)
      cdts_pkg::FLD_WEEKDAY: stepped.weekday = wd_step[2:0];
      cdts_pkg::FLD_DATE:    stepped.date    = dt_step[4:0];
      cdts_pkg::FLD_MONTH:   stepped.month   = mo_step[3:0];
      cdts_pkg::FLD_YEAR:    stepped.year    = yr_step;
      cdts_pkg::FLD_HOUR:    stepped.hour    = hr_step[4:0];
      cdts_pkg::FLD_MINUTE:  stepped.minute  = mi_step[5:0];
      cdts_pkg::FLD_SECOND:  stepped.second  = se_step[5:0];
      default:               stepped = cur;
    endcase
  end

  always_comb begin
    nxt    = cur;
    commit = 1'b0;
    if (req.action == cdts_pkg::ACT_LOAD) begin
      nxt.weekday = (req.load_weekday == 3'd0) ? 3'd1 : req.load_weekday;
      nxt.date    = (req.load_day_of_month == 5'd0) ? 5'd1 : req.load_day_of_month;
      if (req.load_month == 4'd0) begin
        nxt.month = 4'd1;
      end else if (req.load_month > cdts_pkg::MONTH_MAX) begin
        nxt.month = cdts_pkg::MONTH_MAX;
      end else begin
        nxt.month = req.load_month;
      end
      nxt.year   = (req.load_year > cdts_pkg::YEAR_MAX) ? cdts_pkg::YEAR_MAX : req.load_year;
      nxt.hour   = (req.load_hour > cdts_pkg::HOUR_MAX) ? cdts_pkg::HOUR_MAX : req.load_hour;
      nxt.minute = (req.load_minute > cdts_pkg::MINSEC_MAX) ? cdts_pkg::MINSEC_MAX
                                                            : req.load_minute;
      nxt.second = (req.load_second > cdts_pkg::MINSEC_MAX) ? cdts_pkg::MINSEC_MAX
                                                            : req.load_second;
      nxt.cursor = cdts_pkg::FLD_WEEKDAY;
      nxt.active = 1'b1;
    end else if (cur.active) begin
      unique case (req.action)
        cdts_pkg::ACT_SELECT: begin
          commit     = 1'b1;
          nxt.active = 1'b0;
        end
        cdts_pkg::ACT_LEFT: begin
          nxt.cursor = (cur.cursor == cdts_pkg::FLD_WEEKDAY) ? cdts_pkg::FLD_SECOND
                                                             : cur.cursor - 3'd1;
        end
        cdts_pkg::ACT_RIGHT: begin
          nxt.cursor = (cur.cursor >= cdts_pkg::FLD_SECOND) ? cdts_pkg::FLD_WEEKDAY
                                                            : cur.cursor + 3'd1;
        end
        cdts_pkg::ACT_UP,
        cdts_pkg::ACT_DOWN: begin
          nxt = stepped;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

FILE: rtl/clock_date_time_set_editor.sv
// Clock date/time set editor: held state, result register and handshake.
// The result of a request is registered and valid in the cycle after it is accepted.
// Throughput: one request per cycle; the state register doubles as the result
// register, so a new request is taken whenever the result is empty or being taken.
// Reset (synchronous, rst high): not editing, cursor on weekday, values
// 4/5/11/0 9:30:00, no result pending.
module clock_date_time_set_editor (
  input  logic            clk,
  input  logic            rst,
  cdts_in_if.sink         request,
  cdts_out_if.source      result
);

  cdts_pkg::state_t state;
  cdts_pkg::state_t state_next;
  logic             commit;
  logic             commit_next;
  logic             out_valid;
  logic             accept;

  assign request.ready = !out_valid || result.ready;
  assign accept        = request.valid && request.ready;

  cdts_step u_step (
    .cur    (state),
    .req    (request.item),
    .nxt    (state_next),
    .commit (commit_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.active  <= 1'b0;
      state.cursor  <= cdts_pkg::FLD_WEEKDAY;
      state.weekday <= 3'd4;
      state.date    <= 5'd5;
      state.month   <= 4'd11;
      state.year    <= 7'd0;
      state.hour    <= 5'd9;
      state.minute  <= 6'd30;
      state.second  <= 6'd0;
      commit        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        commit    <= commit_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid             = out_valid;
  assign result.item.editing      = state.active;
  assign result.item.cursor       = state.cursor;
  assign result.item.weekday      = state.weekday;
  assign result.item.day_of_month = state.date;
  assign result.item.month        = state.month;
  assign result.item.year         = state.year;
  assign result.item.hour         = state.hour;
  assign result.item.minute       = state.minute;
  assign result.item.second       = state.second;
  assign result.item.commit       = commit;

  // commit always ends editing
  a_commit_ends_edit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.item.commit |-> !result.item.editing)
    else $error("commit shown while still editing");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result.item.cursor != 3'd7)
    else $error("cursor outside field range");

  a_load_starts_edit: assert property (@(posedge clk) disable iff (rst)
    accept && request.item.action == cdts_pkg::ACT_LOAD |=>
      result.valid && result.item.editing && !result.item.commit &&
      result.item.cursor == cdts_pkg::FLD_WEEKDAY)
    else $error("load did not start editing on weekday");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.item))
    else $error("pending result changed under stall");

endmodule

FILE: dv/tb_clock_date_time_set_editor.sv
// Testbench for the clock date/time set editor: directed and random button requests.
`timescale 1ns / 1ps

import cdts_pkg::*;

// Shadow copy of the editor state; predicts the view after each request and checks results.
class editor_shadow;
  logic       active;
  logic [2:0] cursor;
  logic [2:0] weekday;
  logic [4:0] date;
  logic [3:0] month;
  logic [6:0] year;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  out_item_t  awaited_views[$];
  int errors;
  int checked;
  int loads;
  int commits;
  int steps;

  function new();
    active  = 1'b0;
    cursor  = FLD_WEEKDAY;
    weekday = 3'd4;
    date    = 5'd5;
    month   = 4'd11;
    year    = 7'd0;
    hour    = 5'd9;
    minute  = 6'd30;
    second  = 6'd0;
    errors  = 0;
    checked = 0;
    loads   = 0;
    commits = 0;
    steps   = 0;
  endfunction

  function int wrap_next(int v, int lo, int hi, bit up);
    if (up) return (v >= hi) ? lo : v + 1;
    return (v <= lo) ? hi : v - 1;
  endfunction

  function int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function void step_selected(bit up);
    case (cursor)
      FLD_WEEKDAY: weekday = 3'(wrap_next(weekday, 1, WEEKDAY_MAX, up));
      FLD_DATE:    date    = 5'(wrap_next(date, 1, DATE_MAX, up));
      FLD_MONTH:   month   = 4'(wrap_next(month, 1, MONTH_MAX, up));
      FLD_YEAR: begin
        // year saturates instead of wrapping
        if (up && year < YEAR_MAX) year = year + 7'd1;
        else if (!up && year > 0) year = year - 7'd1;
      end
      FLD_HOUR:    hour    = 5'(wrap_next(hour, 0, HOUR_MAX, up));
      FLD_MINUTE:  minute  = 6'(wrap_next(minute, 0, MINSEC_MAX, up));
      FLD_SECOND:  second  = 6'(wrap_next(second, 0, MINSEC_MAX, up));
      default: ;
    endcase
  endfunction

  function void take_request(in_item_t r);
    out_item_t view;
    logic      fire;
    fire = 1'b0;
    if (r.action == ACT_LOAD) begin
      weekday = 3'(clamp(r.load_weekday, 1, WEEKDAY_MAX));
      date    = 5'(clamp(r.load_day_of_month, 1, DATE_MAX));
      month   = 4'(clamp(r.load_month, 1, MONTH_MAX));
      year    = 7'(clamp(r.load_year, 0, YEAR_MAX));
      hour    = 5'(clamp(r.load_hour, 0, HOUR_MAX));
      minute  = 6'(clamp(r.load_minute, 0, MINSEC_MAX));
      second  = 6'(clamp(r.load_second, 0, MINSEC_MAX));
      cursor  = FLD_WEEKDAY;
      active  = 1'b1;
      loads++;
    end else if (active) begin
      case (r.action)
        ACT_SELECT: begin
          fire   = 1'b1;
          active = 1'b0;
          commits++;
        end
        ACT_LEFT:  cursor = (cursor == FLD_WEEKDAY) ? FLD_SECOND : cursor - 3'd1;
        ACT_RIGHT: cursor = (cursor == FLD_SECOND) ? FLD_WEEKDAY : cursor + 3'd1;
        ACT_UP: begin
          step_selected(1'b1);
          steps++;
        end
        ACT_DOWN: begin
          step_selected(1'b0);
          steps++;
        end
        default: ;
      endcase
    end
    view.editing      = active;
    view.cursor       = cursor;
    view.weekday      = weekday;
    view.day_of_month = date;
    view.month        = month;
    view.year         = year;
    view.hour         = hour;
    view.minute       = minute;
    view.second       = second;
    view.commit       = fire;
    awaited_views.push_back(view);
  endfunction

  function void compare_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void match_view(out_item_t got);
    out_item_t want;
    if (awaited_views.size() == 0) begin
      $error("result arrived with no request outstanding");
      errors++;
      return;
    end
    want = awaited_views.pop_front();
    checked++;
    compare_field("editing", want.editing, got.editing);
    compare_field("cursor", want.cursor, got.cursor);
    compare_field("weekday", want.weekday, got.weekday);
    compare_field("day_of_month", want.day_of_month, got.day_of_month);
    compare_field("month", want.month, got.month);
    compare_field("year", want.year, got.year);
    compare_field("hour", want.hour, got.hour);
    compare_field("minute", want.minute, got.minute);
    compare_field("second", want.second, got.second);
    compare_field("commit", want.commit, got.commit);
  endfunction

  function int pending();
    return awaited_views.size();
  endfunction
endclass

module tb_clock_date_time_set_editor;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int REQUEST_TARGET = 650;

  logic clk = 1'b0;
  logic rst;
  bit   idle_en;
  int   sent;
  editor_shadow shadow;

  cdts_in_if  req_if ();
  cdts_out_if res_if ();

  clock_date_time_set_editor DUT (
    .clk     (clk),
    .rst     (rst),
    .request (req_if.sink),
    .result  (res_if.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // results first: they belong to requests taken at earlier edges
  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) shadow.match_view(res_if.item);
      if (req_if.valid && req_if.ready) shadow.take_request(req_if.item);
    end
  end

  always @(negedge clk) begin
    res_if.ready = !(idle_en && $urandom_range(99) < 9);
  end

  function automatic in_item_t random_fields();
    in_item_t r;
    r.action            = ACT_NONE;
    // one field in four is drawn over its full width to hit the saturating loads
    r.load_weekday      = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(7, 1));
    r.load_day_of_month = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(31, 1));
    r.load_month        = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(12, 1));
    r.load_year         = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(99));
    r.load_hour         = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(23));
    r.load_minute       = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(59));
    r.load_second       = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(59));
    return r;
  endfunction

  function automatic logic [2:0] pick_edit();
    int r;
    r = $urandom_range(99);
    if (r < 15) return ACT_LEFT;
    if (r < 40) return ACT_RIGHT;
    if (r < 68) return ACT_UP;
    if (r < 95) return ACT_DOWN;
    return (r % 2 == 0) ? ACT_NONE : ACT_UNUSED;
  endfunction

  // entered and left at a falling edge; valid stays high into back-to-back requests
  task automatic send_request(input in_item_t r);
    while (idle_en && $urandom_range(99) < 9) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.item  = r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic press(input logic [2:0] act);
    in_item_t r;
    r = random_fields();
    r.action = action_t'(act);
    send_request(r);
  endtask

  task automatic load_clock(input int w, input int d, input int m, input int y,
                            input int h, input int mi, input int s);
    in_item_t r;
    r = random_fields();
    r.action            = ACT_LOAD;
    r.load_weekday      = 3'(w);
    r.load_day_of_month = 5'(d);
    r.load_month        = 4'(m);
    r.load_year         = 7'(y);
    r.load_hour         = 5'(h);
    r.load_minute       = 6'(mi);
    r.load_second       = 6'(s);
    send_request(r);
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
  endtask

  initial begin
    bit paused;
    shadow       = new();
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.item  = '0;
    res_if.ready = 1'b0;
    idle_en      = 1'b1;
    sent         = 0;
    paused       = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // not editing yet: these must leave the reset values alone
    press(ACT_SELECT);
    press(ACT_UP);
    press(ACT_UNUSED);
    // zero weekday, date and month clamp up, hour/minute/second clamp down
    load_clock(0, 0, 0, 0, 31, 63, 63);
    press(ACT_DOWN);   // weekday 1 -> 7
    press(ACT_UP);
    press(ACT_RIGHT);
    press(ACT_DOWN);   // date 1 -> 31
    press(ACT_UP);
    press(ACT_RIGHT);
    press(ACT_DOWN);   // month 1 -> 12
    press(ACT_UP);
    press(ACT_RIGHT);
    press(ACT_DOWN);   // year stuck at 0
    press(ACT_RIGHT);
    press(ACT_UP);     // hour 23 -> 0
    press(ACT_RIGHT);
    press(ACT_UP);     // minute 59 -> 0
    press(ACT_RIGHT);
    press(ACT_UP);     // second 59 -> 0
    press(ACT_RIGHT);  // cursor wraps to weekday
    press(ACT_LEFT);   // and back to second
    press(ACT_NONE);
    // reload while editing, month and year over range
    load_clock(7, 31, 15, 127, 23, 59, 59);
    press(ACT_RIGHT);
    press(ACT_RIGHT);
    press(ACT_RIGHT);
    press(ACT_UP);     // year stuck at 99
    press(ACT_SELECT);

    while (sent < REQUEST_TARGET) begin
      idle_en = !(sent > 200 && sent < 380);
      if (!paused && sent > 450) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        press(ACT_LOAD);
        repeat ($urandom_range(20, 1)) press(pick_edit());
        if ($urandom_range(99) < 85) press(ACT_SELECT);
      end else begin
        repeat ($urandom_range(4, 1)) press(3'($urandom));
      end
    end

    drain();
    repeat (4) @(negedge clk);
    $display("Checked %0d results for %0d requests: %0d loads, %0d commits, %0d field steps.",
             shadow.checked, sent, shadow.loads, shadow.commits, shadow.steps);
    $display("Included wrap and saturation at field limits, idle presses and clamped loads.");
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: files.f
rtl/cdts_pkg.sv
rtl/cdts_in_if.sv
rtl/cdts_out_if.sv
rtl/cdts_step.sv
rtl/clock_date_time_set_editor.sv
dv/tb_clock_date_time_set_editor.sv
